### hdl/fesp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Figure-eight path stepper package
// Shared widths, reset values, register indexes and controller commands.
// ----------------------------------------------------------------------------
package fesp_pkg;

   localparam int SINE_TABLE_BITS_DEFAULT = 10;
   localparam int PHASE_BITS_DEFAULT      = 32;

   localparam int ELAPSED_W  = 16;
   localparam int COORD_W    = 16;
   localparam int HEIGHT_W   = 15;
   localparam int MOVE_W     = 17;
   localparam int RATE_W     = 24;
   localparam int AMP_W      = 11;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [RATE_W-1:0] PHASE_RATE_RESET = 24'd42722;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RESET  = 11'd100;

   // pi/2 in Q30, used to build the quarter-wave sine table.
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_RATE = 2'd0,
      CSR_AMPLITUDE  = 2'd1
   } csr_index_type;

   // One command per datapath step; the controller raises at most one per cycle.
   typedef struct packed {
      logic capture;
      logic step_phase;
      logic read_sin;
      logic read_cos;
      logic mul_amp;
      logic mul_x;
      logic emit;
   } fesp_cmd_type;

endpackage

### hdl/fesp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick request channel
// Valid/ready channel carrying one tick: elapsed time and platform geometry.
// ----------------------------------------------------------------------------
interface fesp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [fesp_pkg::ELAPSED_W-1:0] elapsed;
   logic signed [fesp_pkg::COORD_W-1:0]   platform_top;
   logic        [fesp_pkg::HEIGHT_W-1:0]  platform_height;
   logic signed [fesp_pkg::COORD_W-1:0]   view_top;

   modport source (output valid, elapsed, platform_top, platform_height, view_top,
                   input ready);
   modport sink (input valid, elapsed, platform_top, platform_height, view_top,
                 output ready);
endinterface

// ----------------------------------------------------------------------------
// Move response channel
// Valid/ready channel carrying the move of one tick and the consumed flag.
// ----------------------------------------------------------------------------
interface fesp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fesp_pkg::MOVE_W-1:0]  move_x;
   logic signed [fesp_pkg::MOVE_W-1:0]  move_y;
   logic                                consumed;

   modport source (output valid, move_x, move_y, consumed, input ready);
   modport sink (input valid, move_x, move_y, consumed, output ready);
endinterface

### hdl/fesp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Figure-eight path stepper controller
// Sequences one tick through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module fesp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fesp_pkg::fesp_cmd_type cmd
);
   import fesp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PHASE  = 7'b0000010,
      ST_RD_SIN = 7'b0000100,
      ST_RD_COS = 7'b0001000,
      ST_MUL_A  = 7'b0010000,
      ST_MUL_X  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PHASE;
            end
         end
         ST_PHASE: begin
            cmd.step_phase = 1'b1;
            state_in       = ST_RD_SIN;
         end
         ST_RD_SIN: begin
            cmd.read_sin = 1'b1;
            state_in     = ST_RD_COS;
         end
         ST_RD_COS: begin
            cmd.read_cos = 1'b1;
            state_in     = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_amp = 1'b1;
            state_in    = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/fesp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Figure-eight path stepper datapath
// Phase accumulator, quarter-wave sine ROM, multipliers and output registers.
// ----------------------------------------------------------------------------
module fesp_datapath #(
   parameter int SINE_TABLE_BITS = fesp_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = fesp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fesp_pkg::fesp_cmd_type                 cmd,
   input  logic                                   csr_write_en,
   input  logic [fesp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fesp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic        [fesp_pkg::ELAPSED_W-1:0]  req_elapsed,
   input  logic signed [fesp_pkg::COORD_W-1:0]    req_platform_top,
   input  logic        [fesp_pkg::HEIGHT_W-1:0]   req_platform_height,
   input  logic signed [fesp_pkg::COORD_W-1:0]    req_view_top,
   output logic signed [fesp_pkg::MOVE_W-1:0]     rsp_move_x,
   output logic signed [fesp_pkg::MOVE_W-1:0]     rsp_move_y,
   output logic                                   rsp_consumed
);
   import fesp_pkg::*;

   localparam int TableSize = (1 << SINE_TABLE_BITS) + 1;
   localparam int AddrW     = SINE_TABLE_BITS + 1;
   localparam int ProdW     = ELAPSED_W + RATE_W;
   localparam int IncW      = (PHASE_BITS > ProdW + 1) ? PHASE_BITS : ProdW + 1;
   localparam int SineW     = 17;
   localparam int AsW       = 28;
   localparam int AscW      = AsW + SineW;

   typedef logic [15:0] rom_word_type;
   typedef rom_word_type rom_array_type [TableSize];

   // Quarter-wave sine in Q15 from a Taylor series in Q30, evaluated at elaboration.
   function automatic rom_array_type build_table();
      rom_array_type t;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   term;
      logic [63:0]   sum;
      logic [63:0]   r;
      int            k;
      int            n;
      for (k = 0; k < TableSize; k++) begin
         x    = (PI_HALF_Q30 * 64'(k)) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         r = (sum + 64'd16384) >> 15;
         if (r > 64'd32768) begin
            r = 64'd32768;
         end
         t[k] = r[15:0];
      end
      return t;
   endfunction

   localparam rom_array_type SINE_ROM = build_table();

   // Configuration registers.
   logic [RATE_W-1:0] phase_rate_ff;
   logic [AMP_W-1:0]  amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_rate_ff <= PHASE_RATE_RESET;
         amplitude_ff  <= AMPLITUDE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PHASE_RATE: phase_rate_ff <= csr_wdata[RATE_W-1:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Tick capture: rate product and consumed test.
   logic [ProdW-1:0]     prod_ff, prod_in;
   logic                 consumed_ff, consumed_in;
   logic signed [COORD_W:0] bottom;

   assign prod_in     = ProdW'(req_elapsed) * ProdW'(phase_rate_ff);
   assign bottom      = (COORD_W+1)'(req_platform_top) +
                        (COORD_W+1)'(signed'({1'b0, req_platform_height}));
   assign consumed_in = (bottom < (COORD_W+1)'(req_view_top));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff     <= prod_in;
         consumed_ff <= consumed_in;
      end
   end

   // Phase accumulator, advanced by twice the rate product, wrapping.
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [IncW-1:0]       inc_wide;

   assign inc_wide = IncW'({prod_ff, 1'b0});
   assign phase_in = phase_ff + inc_wide[PHASE_BITS-1:0];

   // ROM addressing: the cosine uses the next quadrant with the same index.
   logic [1:0]                 quad_sin, quad_cos, quad_sel;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [AddrW-1:0]           rom_addr;
   rom_word_type               rom_data_ff;
   logic                       rom_neg_ff;
   logic signed [SineW-1:0]    rom_value;

   assign quad_sin = phase_ff[PHASE_BITS-1 -: 2];
   assign quad_cos = quad_sin + 2'd1;
   assign tab_idx  = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign quad_sel = cmd.read_cos ? quad_cos : quad_sin;
   assign rom_addr = quad_sel[0] ? AddrW'((1 << SINE_TABLE_BITS) - int'(tab_idx))
                                 : AddrW'(tab_idx);

   always_ff @(posedge clock) begin
      if (cmd.read_sin || cmd.read_cos) begin
         rom_data_ff <= SINE_ROM[rom_addr];
         rom_neg_ff  <= quad_sel[1];
      end
   end

   assign rom_value = rom_neg_ff ? -signed'({1'b0, rom_data_ff})
                                 :  signed'({1'b0, rom_data_ff});

   // Multiplies and rounding (half away from zero, on the magnitude).
   logic signed [SineW-1:0] s_ff, c_ff;
   logic signed [AsW-1:0]   as_ff, as_in;
   logic signed [AscW-1:0]  asc_ff;
   logic [AsW-1:0]          as_mag;
   logic [AscW-1:0]         asc_mag;
   logic [AsW-1:0]          y_rnd;
   logic [AscW-1:0]         x_rnd;
   logic signed [COORD_W-1:0] ny_ff, ny_in, nx_in;

   assign as_in   = AsW'(signed'({1'b0, amplitude_ff})) * AsW'(s_ff);
   assign as_mag  = as_ff[AsW-1] ? AsW'(-as_ff) : AsW'(as_ff);
   assign y_rnd   = (as_mag + AsW'(1 << 10)) >> 11;
   assign ny_in   = as_ff[AsW-1] ? -signed'(y_rnd[COORD_W-1:0])
                                 :  signed'(y_rnd[COORD_W-1:0]);
   assign asc_mag = asc_ff[AscW-1] ? AscW'(-asc_ff) : AscW'(asc_ff);
   assign x_rnd   = (asc_mag + AscW'(64'd1 << 26)) >> 27;
   assign nx_in   = asc_ff[AscW-1] ? -signed'(x_rnd[COORD_W-1:0])
                                   :  signed'(x_rnd[COORD_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.read_cos) begin
         s_ff <= rom_value;
      end
      if (cmd.mul_amp) begin
         c_ff  <= rom_value;
         as_ff <= as_in;
      end
      if (cmd.mul_x) begin
         asc_ff <= AscW'(as_ff) * AscW'(c_ff);
         ny_ff  <= ny_in;
      end
   end

   // Tick state: phase and the previous offsets.
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         if (cmd.step_phase) begin
            phase_ff <= phase_in;
         end
         if (cmd.emit) begin
            prev_x_ff <= nx_in;
            prev_y_ff <= ny_ff;
         end
      end
   end

   // Output register.
   logic signed [MOVE_W-1:0] move_x_ff, move_y_ff;
   logic                     out_consumed_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         move_x_ff       <= MOVE_W'(nx_in) - MOVE_W'(prev_x_ff);
         move_y_ff       <= MOVE_W'(ny_ff) - MOVE_W'(prev_y_ff);
         out_consumed_ff <= consumed_ff;
      end
   end

   assign rsp_move_x   = move_x_ff;
   assign rsp_move_y   = move_y_ff;
   assign rsp_consumed = out_consumed_ff;

endmodule

### hdl/figure_eight_path_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Figure-eight path stepper
// Moves a platform along a lemniscate of Gerono, one tick at a time.
// ----------------------------------------------------------------------------
// Each transfer on req_if brings the time elapsed since the last tick and the
// platform and view geometry. The block advances its phase by twice elapsed
// times phase_rate, looks up sine and cosine in a quarter-wave ROM, and
// returns on rsp_if the move from the previous offsets in 1/16 pixel, plus a
// flag that is set when the platform bottom lies above the view top.
// The response is valid once the request transfer, which also captures the
// rate product, has been followed by these steps in order: the phase add, the
// sine and cosine reads of the shared single-port sine ROM, the amplitude and
// cross multiplies, and the load of the output register. The controller works
// on one tick at a time, so no new tick is taken until the last one is emitted.
// req_if.ready is high only while the block is idle.
// If the receiver stalls, the finished response waits in the output register;
// the next tick is still taken and runs up to its final step, where it waits
// until the previous response has been transferred.
// The csr_ port writes phase_rate (index 0) and amplitude (index 1); write
// them only while no tick is in flight. A synchronous reset restores the
// register defaults, zeroes phase and offsets, and drops valid.
// ----------------------------------------------------------------------------
module figure_eight_path_stepper #(
   parameter int SINE_TABLE_BITS = fesp_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = fesp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   fesp_req_if.sink                         req_if,
   fesp_rsp_if.source                       rsp_if,
   input  logic                             csr_write_en,
   input  logic [fesp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fesp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fesp_pkg::*;

   fesp_cmd_type cmd;

   // The controller sequences the steps and owns valid and ready.
   fesp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // The datapath holds configuration, phase, offsets and the response payload.
   fesp_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_elapsed         (req_if.elapsed),
      .req_platform_top    (req_if.platform_top),
      .req_platform_height (req_if.platform_height),
      .req_view_top        (req_if.view_top),
      .rsp_move_x          (rsp_if.move_x),
      .rsp_move_y          (rsp_if.move_y),
      .rsp_consumed        (rsp_if.consumed)
   );

endmodule
